/* hdl/hsa_pkg.sv */
package hsa_pkg;

   localparam int BLOCK_SLOTS_DEF   = 256;
   localparam int MAX_SLOTS_DEF     = 1024;
   localparam int MIN_RECLAIMED_DEF = 64;

   localparam int HANDLE_W = 10;
   localparam int WORD_W   = 32;

   typedef enum logic [1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_LOOKUP  = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_FULL    = 2'd1,
      STS_BAD     = 2'd2,
      STS_UNUSED  = 2'd3
   } status_type;

   // write enables towards the slot memories
   typedef struct packed {
      logic link_we;
      logic word_we;
   } wen_type;

endpackage

/* hdl/hsa_if.sv */
interface hsa_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       command;
   logic [hsa_pkg::HANDLE_W-1:0]     handle;
   logic [hsa_pkg::WORD_W-1:0]       value_word;
   logic [hsa_pkg::WORD_W-1:0]       extra_word;
   modport source (output valid, command, handle, value_word, extra_word, input ready);
   modport sink   (input valid, command, handle, value_word, extra_word, output ready);
endinterface

interface hsa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       status;
   logic [hsa_pkg::HANDLE_W-1:0]     handle_out;
   logic [hsa_pkg::WORD_W-1:0]       value_out;
   logic [hsa_pkg::WORD_W-1:0]       extra_out;
   modport source (output valid, status, handle_out, value_out, extra_out, input ready);
   modport sink   (input valid, status, handle_out, value_out, extra_out, output ready);
endinterface

interface hsa_csr_if;
   logic valid;
   logic ready;
   logic strict_fifo;
   modport source (output valid, strict_fifo, input ready);
   modport sink   (input valid, strict_fifo, output ready);
endinterface

/* hdl/hsa_slot_mem.sv */
module hsa_slot_mem #(
   parameter int MAX_SLOTS = hsa_pkg::MAX_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic [$clog2(MAX_SLOTS)-1:0]      rd_addr,
   output logic                              rd_in_use,
   output logic [$clog2(MAX_SLOTS+1)-1:0]    rd_link,
   output logic [hsa_pkg::WORD_W-1:0]        rd_value,
   output logic [hsa_pkg::WORD_W-1:0]        rd_extra,
   input  hsa_pkg::wen_type                  wen,
   input  logic [$clog2(MAX_SLOTS)-1:0]      wr_addr,
   input  logic                              wr_in_use,
   input  logic [$clog2(MAX_SLOTS+1)-1:0]    wr_link,
   input  logic [hsa_pkg::WORD_W-1:0]        wr_value,
   input  logic [hsa_pkg::WORD_W-1:0]        wr_extra
);
   localparam int LW = $clog2(MAX_SLOTS+1);
   localparam int WW = hsa_pkg::WORD_W;

   logic [LW:0]     slot_mem_ff [MAX_SLOTS];
   logic [2*WW-1:0] word_mem_ff [MAX_SLOTS];
   logic [LW:0]     rd_slot_ff;
   logic [2*WW-1:0] rd_word_ff;

   // in-use flag and free link share one entry
   always_ff @(posedge clock) begin
      if (wen.link_we) begin
         slot_mem_ff[wr_addr] <= {wr_in_use, wr_link};
      end
      rd_slot_ff <= slot_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wen.word_we) begin
         word_mem_ff[wr_addr] <= {wr_value, wr_extra};
      end
      rd_word_ff <= word_mem_ff[rd_addr];
   end

   assign rd_in_use = rd_slot_ff[LW];
   assign rd_link   = rd_slot_ff[LW-1:0];
   assign rd_value  = rd_word_ff[2*WW-1:WW];
   assign rd_extra  = rd_word_ff[WW-1:0];

endmodule

/* hdl/handle_slot_allocator.sv */
// Handle slot allocator: create takes a slot off the main free list and
// stores two words, destroy returns a slot in use, lookup reads its words.
// One request is worked on at a time through a small sequencer around a single
// slot memory port (one read, one write a cycle, read data registered).
// Destroy and lookup pass a check state, a create from a non-empty list a
// pop read and a pop write state; each ends in a done state. A create that
// finds the main list empty first moves the alternate list over; in strict
// FIFO mode that list is reversed with a read and a write state per slot.
// Growth links a new block at one slot a cycle. After reset the first
// block is linked by the same walk, during which no word is accepted;
// configuration writes are always taken.
module handle_slot_allocator #(
   parameter int BLOCK_SLOTS   = hsa_pkg::BLOCK_SLOTS_DEF,
   parameter int MAX_SLOTS     = hsa_pkg::MAX_SLOTS_DEF,
   parameter int MIN_RECLAIMED = hsa_pkg::MIN_RECLAIMED_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hsa_req_if.sink    req_ch,
   hsa_rsp_if.source  rsp_ch,
   hsa_csr_if.sink    csr_ch
);
   localparam int LW = $clog2(MAX_SLOTS+1);
   localparam int IW = $clog2(MAX_SLOTS);
   localparam int HW = hsa_pkg::HANDLE_W;
   localparam int WW = hsa_pkg::WORD_W;
   localparam int FIRST_BLOCK = (BLOCK_SLOTS < MAX_SLOTS) ? BLOCK_SLOTS : MAX_SLOTS;
   localparam logic [LW-1:0] END_LINK = LW'(MAX_SLOTS);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CHECK  = 8'b0000_0010,
      ST_REV_RD = 8'b0000_0100,
      ST_REV_WR = 8'b0000_1000,
      ST_GROW   = 8'b0001_0000,
      ST_POP_RD = 8'b0010_0000,
      ST_POP_WR = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   logic [HW-1:0]     h_ff, h_in;
   logic [WW-1:0]     vw_ff, vw_in, ew_ff, ew_in;
   logic [LW-1:0]     main_ff, main_in, alt_ff, alt_in, limit_ff, limit_in;
   logic [LW-1:0]     cur_ff, cur_in, prev_ff, prev_in, cnt_ff, cnt_in;
   logic [LW-1:0]     gidx_ff, gidx_in, gend_ff, gend_in;
   logic              init_ff, init_in, fifo_ff, fifo_in;
   logic [1:0]        res_sts_ff, res_sts_in;
   logic [HW-1:0]     res_h_ff, res_h_in;
   logic [WW-1:0]     res_v_ff, res_v_in, res_e_ff, res_e_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_sts_ff, rsp_sts_in;
   logic [HW-1:0]     rsp_h_ff, rsp_h_in;
   logic [WW-1:0]     rsp_v_ff, rsp_v_in, rsp_e_ff, rsp_e_in;

   logic [IW-1:0]     rd_addr, wr_addr;
   logic              rd_in_use, wr_in_use;
   logic [LW-1:0]     rd_link, wr_link, link_clamped;
   logic [WW-1:0]     rd_value, rd_extra;
   hsa_pkg::wen_type  wen;
   logic [LW-1:0]     grow_room, grow_n, cnt_next;
   logic              slot_ok;

   hsa_slot_mem #(.MAX_SLOTS(MAX_SLOTS)) u_mem (
      .clock     (clock),
      .rd_addr   (rd_addr),
      .rd_in_use (rd_in_use),
      .rd_link   (rd_link),
      .rd_value  (rd_value),
      .rd_extra  (rd_extra),
      .wen       (wen),
      .wr_addr   (wr_addr),
      .wr_in_use (wr_in_use),
      .wr_link   (wr_link),
      .wr_value  (vw_ff),
      .wr_extra  (ew_ff)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_sts_ff;
   assign rsp_ch.handle_out = rsp_h_ff;
   assign rsp_ch.value_out  = rsp_v_ff;
   assign rsp_ch.extra_out  = rsp_e_ff;

   // treat any damaged link as end of list
   assign link_clamped = (rd_link >= END_LINK) ? END_LINK : rd_link;
   // room left below the top and the size of the next block
   assign grow_room = END_LINK - limit_ff;
   assign grow_n    = (32'(grow_room) < 32'(BLOCK_SLOTS)) ? grow_room : LW'(BLOCK_SLOTS);
   assign cnt_next  = cnt_ff + LW'(1);
   assign slot_ok   = (32'(h_ff) < 32'(limit_ff)) && rd_in_use;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      h_in       = h_ff;
      vw_in      = vw_ff;
      ew_in      = ew_ff;
      main_in    = main_ff;
      alt_in     = alt_ff;
      limit_in   = limit_ff;
      cur_in     = cur_ff;
      prev_in    = prev_ff;
      cnt_in     = cnt_ff;
      gidx_in    = gidx_ff;
      gend_in    = gend_ff;
      init_in    = init_ff;
      fifo_in    = fifo_ff;
      res_sts_in = res_sts_ff;
      res_h_in   = res_h_ff;
      res_v_in   = res_v_ff;
      res_e_in   = res_e_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      rsp_sts_in = rsp_sts_ff;
      rsp_h_in   = rsp_h_ff;
      rsp_v_in   = rsp_v_ff;
      rsp_e_in   = rsp_e_ff;
      rd_addr    = IW'(h_ff);
      wr_addr    = IW'(h_ff);
      wr_in_use  = 1'b0;
      wr_link    = END_LINK;
      wen        = '0;

      if (csr_ch.valid) begin
         fifo_in = csr_ch.strict_fifo;
      end

      case (state_ff)
         ST_IDLE: begin
            rd_addr = IW'(req_ch.handle);
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               h_in     = req_ch.handle;
               vw_in    = req_ch.value_word;
               ew_in    = req_ch.extra_word;
               res_sts_in = hsa_pkg::STS_BAD;
               res_h_in = req_ch.handle;
               res_v_in = '0;
               res_e_in = '0;
               case (hsa_pkg::cmd_type'(req_ch.command))
                  hsa_pkg::CMD_CREATE: begin
                     if (main_ff != END_LINK) begin
                        state_in = ST_POP_RD;
                     end else begin
                        // main list dry: take over the alternate list
                        alt_in = END_LINK;
                        if (alt_ff == END_LINK) begin
                           state_in = ST_GROW;
                           gidx_in  = limit_ff;
                           gend_in  = limit_ff + grow_n;
                        end else if (!fifo_ff) begin
                           main_in  = alt_ff;
                           state_in = ST_POP_RD;
                        end else begin
                           cur_in   = alt_ff;
                           prev_in  = END_LINK;
                           cnt_in   = '0;
                           state_in = ST_REV_RD;
                        end
                     end
                  end
                  hsa_pkg::CMD_DESTROY, hsa_pkg::CMD_LOOKUP: begin
                     state_in = ST_CHECK;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_CHECK: begin
            if (slot_ok) begin
               res_sts_in = hsa_pkg::STS_OK;
               if (cmd_ff == hsa_pkg::CMD_LOOKUP) begin
                  res_v_in = rd_value;
                  res_e_in = rd_extra;
               end else begin
                  // push the freed slot on the list the mode selects
                  wen.link_we = 1'b1;
                  wr_link     = fifo_ff ? alt_ff : main_ff;
                  if (fifo_ff) begin
                     alt_in  = LW'(h_ff);
                  end else begin
                     main_in = LW'(h_ff);
                  end
               end
            end
            state_in = ST_DONE;
         end

         ST_REV_RD: begin
            rd_addr  = cur_ff[IW-1:0];
            state_in = ST_REV_WR;
         end

         ST_REV_WR: begin
            // turn the link of the current slot round
            wr_addr     = cur_ff[IW-1:0];
            wen.link_we = 1'b1;
            wr_link     = prev_ff;
            prev_in     = cur_ff;
            cnt_in      = cnt_next;
            if (link_clamped == END_LINK || cnt_next == END_LINK) begin
               main_in = cur_ff;
               if (fifo_ff && 32'(cnt_next) < 32'(MIN_RECLAIMED)) begin
                  state_in = ST_GROW;
                  gidx_in  = limit_ff;
                  gend_in  = limit_ff + grow_n;
               end else begin
                  state_in = ST_POP_RD;
               end
            end else begin
               cur_in   = link_clamped;
               state_in = ST_REV_RD;
            end
         end

         ST_GROW: begin
            if (limit_ff >= END_LINK) begin
               state_in = init_ff ? ST_IDLE : ST_POP_RD;
               init_in  = 1'b0;
            end else begin
               // link the new block in ascending order, last onto the list
               wr_addr     = gidx_ff[IW-1:0];
               wen.link_we = 1'b1;
               gidx_in     = gidx_ff + LW'(1);
               if (gidx_ff + LW'(1) == gend_ff) begin
                  wr_link  = main_ff;
                  main_in  = limit_ff;
                  limit_in = gend_ff;
                  state_in = init_ff ? ST_IDLE : ST_POP_RD;
                  init_in  = 1'b0;
               end else begin
                  wr_link  = gidx_ff + LW'(1);
               end
            end
         end

         ST_POP_RD: begin
            rd_addr = main_ff[IW-1:0];
            if (main_ff == END_LINK) begin
               res_sts_in = hsa_pkg::STS_FULL;
               state_in   = ST_DONE;
            end else begin
               state_in   = ST_POP_WR;
            end
         end

         ST_POP_WR: begin
            wr_addr     = main_ff[IW-1:0];
            wen.link_we = 1'b1;
            wen.word_we = 1'b1;
            wr_in_use   = 1'b1;
            wr_link     = rd_link;
            main_in     = link_clamped;
            res_sts_in  = hsa_pkg::STS_OK;
            res_h_in    = HW'(main_ff);
            state_in    = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_sts_in   = res_sts_ff;
               rsp_h_in     = res_h_ff;
               rsp_v_in     = res_v_ff;
               rsp_e_in     = res_e_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_GROW;
         init_ff      <= 1'b1;
         main_ff      <= END_LINK;
         alt_ff       <= END_LINK;
         limit_ff     <= '0;
         gidx_ff      <= '0;
         gend_ff      <= LW'(FIRST_BLOCK);
         fifo_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         main_ff      <= main_in;
         alt_ff       <= alt_in;
         limit_ff     <= limit_in;
         gidx_ff      <= gidx_in;
         gend_ff      <= gend_in;
         fifo_ff      <= fifo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      h_ff       <= h_in;
      vw_ff      <= vw_in;
      ew_ff      <= ew_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      cnt_ff     <= cnt_in;
      res_sts_ff <= res_sts_in;
      res_h_ff   <= res_h_in;
      res_v_ff   <= res_v_in;
      res_e_ff   <= res_e_in;
      rsp_sts_ff <= rsp_sts_in;
      rsp_h_ff   <= rsp_h_in;
      rsp_v_ff   <= rsp_v_in;
      rsp_e_ff   <= rsp_e_in;
   end

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_limit_range: assert property (@(posedge clock) disable iff (reset)
      limit_ff <= END_LINK)
      else $error("grown limit beyond table");

   a_head_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (main_ff == END_LINK || main_ff < limit_ff))
      else $error("main free head outside grown table");
`endif

endmodule
